[hdl/elp_pkg.sv]
// shared types, widths and helper functions for the erlang loss probability block
package elp_pkg;

  localparam int CHAN_W  = 5;
  localparam int ALPHA_W = 20;
  localparam int TERM_W  = 40;
  localparam int OUT_W   = 17;

  localparam logic [TERM_W-1:0] WIDE_MAX = '1;
  localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_TLOAD,
    ST_TDIV,
    ST_ACC,
    ST_FDIV,
    ST_BLOAD,
    ST_BMUL,
    ST_OUT
  } elp_state_e;

  typedef struct packed {
    logic load_item;
    logic mul_load_alpha;
    logic mul_load_p0;
    logic mul_step;
    logic div_load_term;
    logic div_load_final;
    logic div_step;
    logic acc_update;
    logic out_load;
  } elp_cmd_t;

  typedef struct packed {
    logic k_over_n;
  } elp_sts_t;

  // multiplier operand width: wide enough for alpha and for p0, rounded up to even
  function automatic int mul_w(input int frac);
    int w;
    begin
      w = (frac + 1 > ALPHA_W) ? frac + 1 : ALPHA_W;
      return w + (w % 2);
    end
  endfunction

  // quotient bits kept by the divider
  function automatic int quot_w(input int frac);
    begin
      return TERM_W + ALPHA_W - frac;
    end
  endfunction

endpackage

[hdl/elp_ctrl.sv]
// sequencer for the term loop, the reciprocal and the final multiply
module elp_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  elp_pkg::elp_sts_t sts_i,
  output elp_pkg::elp_cmd_t cmd_o
);
  import elp_pkg::*;

  localparam int MUL_STEPS = mul_w(FRAC_BITS) / 2;
  localparam int QW        = quot_w(FRAC_BITS);
  localparam int CNT_W     = $clog2(QW);

  elp_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.k_over_n ? ST_FDIV : ST_MUL;
      ST_MUL:   if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = ST_TLOAD;
      ST_TLOAD: state_d = ST_TDIV;
      ST_TDIV:  if (cnt_q == CNT_W'(QW - 1)) state_d = ST_ACC;
      ST_ACC:   state_d = ST_CHECK;
      ST_FDIV:  if (cnt_q == CNT_W'(FRAC_BITS)) state_d = ST_BLOAD;
      ST_BLOAD: state_d = ST_BMUL;
      ST_BMUL:  if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:  cmd_o.load_item = in_valid_i;
      ST_CHECK: begin
        cmd_o.div_load_final = sts_i.k_over_n;
        cmd_o.mul_load_alpha = !sts_i.k_over_n;
      end
      ST_MUL:   cmd_o.mul_step = 1'b1;
      ST_TLOAD: cmd_o.div_load_term = 1'b1;
      ST_TDIV:  cmd_o.div_step = 1'b1;
      ST_ACC:   cmd_o.acc_update = 1'b1;
      ST_FDIV:  cmd_o.div_step = 1'b1;
      ST_BLOAD: cmd_o.mul_load_p0 = 1'b1;
      ST_BMUL:  cmd_o.mul_step = 1'b1;
      ST_OUT:   cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    if (state_d != state_q) begin
      cnt_d = '0;
    end else if (state_q == ST_MUL || state_q == ST_TDIV || state_q == ST_FDIV ||
                 state_q == ST_BMUL) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // result register empties on a transfer and refills from the datapath
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/elp_dpath.sv]
// datapath: running term and sum, radix-4 serial multiplier, restoring divider
module elp_dpath #(
  parameter int MAX_CHANNELS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  elp_pkg::elp_cmd_t            cmd_i,
  output elp_pkg::elp_sts_t            sts_o,
  input  logic [elp_pkg::CHAN_W-1:0]   channels_i,
  input  logic [elp_pkg::ALPHA_W-1:0]  offered_load_i,
  output logic [elp_pkg::OUT_W-1:0]    idle_probability_o,
  output logic [elp_pkg::OUT_W-1:0]    block_probability_o
);
  import elp_pkg::*;

  localparam int MUL_W  = mul_w(FRAC_BITS);
  localparam int P_W    = TERM_W + 2 + MUL_W;
  localparam int PROD_W = TERM_W + ALPHA_W;
  localparam int QW     = quot_w(FRAC_BITS);
  localparam int N_W    = $clog2(MAX_CHANNELS + 1);
  localparam int K_W    = $clog2(MAX_CHANNELS + 2);

  logic [N_W-1:0]     n_q, n_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic [TERM_W-1:0]  term_q, term_d;
  logic [TERM_W-1:0]  sum_q, sum_d;
  logic [TERM_W+1:0]  term3_q, term3_d;
  logic [P_W-1:0]     prod_q, prod_d;
  logic [TERM_W-1:0]  rem_q, rem_d;
  logic [QW-1:0]      quot_q, quot_d;
  logic [TERM_W-1:0]  dvsr_q, dvsr_d;
  logic [OUT_W-1:0]   idle_q, idle_d;
  logic [OUT_W-1:0]   blk_q, blk_d;

  logic [CHAN_W:0]    chan_ext;
  logic [TERM_W+1:0]  addend;
  logic [TERM_W+1:0]  hi_sum;
  logic [TERM_W:0]    trial;
  logic [TERM_W:0]    diff;
  logic               fits;
  logic [TERM_W-1:0]  q_sat;
  logic [TERM_W:0]    sum_ext;
  logic [FRAC_BITS:0] p0;
  logic [63:0]        blk_wide;

  assign chan_ext     = {1'b0, channels_i};
  assign sts_o.k_over_n = (k_q > K_W'(n_q));

  // two multiplier bits per cycle, accumulator shifts right
  always_comb begin
    case (prod_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, term_q};
      2'd2:    addend = {1'b0, term_q, 1'b0};
      default: addend = term3_q;
    endcase
  end
  assign hi_sum = prod_q[P_W-1:MUL_W] + addend;

  // one quotient bit per cycle
  assign trial = {rem_q, quot_q[QW-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign fits  = (trial >= {1'b0, dvsr_q});

  assign q_sat   = (64'(quot_q) > 64'(WIDE_MAX)) ? WIDE_MAX : TERM_W'(quot_q);
  assign sum_ext = {1'b0, sum_q} + {1'b0, q_sat};

  assign p0       = quot_q[FRAC_BITS:0];
  assign blk_wide = 64'(prod_q[TERM_W+MUL_W-1:FRAC_BITS]);

  always_comb begin
    n_d     = n_q;
    k_d     = k_q;
    alpha_d = alpha_q;
    term_d  = term_q;
    sum_d   = sum_q;
    if (cmd_i.load_item) begin
      if (chan_ext > (CHAN_W+1)'(MAX_CHANNELS)) begin
        n_d = N_W'(MAX_CHANNELS);
      end else begin
        n_d = N_W'(channels_i);
      end
      k_d     = K_W'(1);
      alpha_d = offered_load_i;
      term_d  = TERM_W'(1) << FRAC_BITS;
      sum_d   = TERM_W'(1) << FRAC_BITS;
    end else if (cmd_i.acc_update) begin
      k_d    = k_q + K_W'(1);
      term_d = q_sat;
      sum_d  = sum_ext[TERM_W] ? WIDE_MAX : sum_ext[TERM_W-1:0];
    end
  end

  always_comb begin
    prod_d  = prod_q;
    term3_d = term3_q;
    if (cmd_i.mul_load_alpha || cmd_i.mul_load_p0) begin
      term3_d = {2'b00, term_q} + {1'b0, term_q, 1'b0};
      prod_d  = cmd_i.mul_load_alpha ? P_W'(alpha_q) : P_W'(p0);
    end else if (cmd_i.mul_step) begin
      prod_d = {2'b00, hi_sum, prod_q[MUL_W-1:2]};
    end
  end

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dvsr_d = dvsr_q;
    if (cmd_i.div_load_term) begin
      // divide by k * 2^F: the top F bits of the product seed the remainder
      rem_d  = TERM_W'(prod_q[PROD_W-1:QW]);
      quot_d = prod_q[QW-1:0];
      dvsr_d = TERM_W'(k_q) << FRAC_BITS;
    end else if (cmd_i.div_load_final) begin
      // 2^(2F) / sum with only the low F+1 quotient bits live
      rem_d  = TERM_W'(1) << (FRAC_BITS - 1);
      quot_d = '0;
      dvsr_d = sum_q;
    end else if (cmd_i.div_step) begin
      rem_d  = fits ? diff[TERM_W-1:0] : trial[TERM_W-1:0];
      quot_d = {quot_q[QW-2:0], fits};
    end
  end

  always_comb begin
    idle_d = idle_q;
    blk_d  = blk_q;
    if (cmd_i.out_load) begin
      idle_d = (64'(p0) > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(p0);
      blk_d  = (blk_wide > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(blk_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      k_q    <= '0;
      term_q <= '0;
      sum_q  <= '0;
    end else begin
      n_q    <= n_d;
      k_q    <= k_d;
      term_q <= term_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
    term3_q <= term3_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    dvsr_q  <= dvsr_d;
    idle_q  <= idle_d;
    blk_q   <= blk_d;
  end

  assign idle_probability_o  = idle_q;
  assign block_probability_o = blk_q;

endmodule

[hdl/erlang_loss_probability.sv]
// Erlang B loss probability: idle probability P0 = 1/S and blocking probability
// P0 * alpha^n/n!, where S sums alpha^k/k! for k = 0..n and each term comes from the
// previous one as term*alpha/k, all with truncating fixed point (FRAC_BITS fraction
// bits, 40-bit term and sum that saturate, n clamped to MAX_CHANNELS). One item is in
// flight at a time. Each term passes through the radix-4 shift-add multiplier over MUL_W
// operand bits (MUL_W = larger of 20 and FRAC_BITS+1, made even), the one-bit-per-cycle
// restoring divider for 60-FRAC_BITS quotient bits and the check, load and accumulate
// states; the reciprocal keeps FRAC_BITS+1 divider quotient bits and the final product
// takes another multiplier pass. A finished result waits in an output register, and
// the next item is taken once the sequencer is back in idle.
module erlang_loss_probability #(
  parameter int MAX_CHANNELS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [elp_pkg::CHAN_W-1:0]   channels_i,
  input  logic [elp_pkg::ALPHA_W-1:0]  offered_load_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [elp_pkg::OUT_W-1:0]    idle_probability_o,
  output logic [elp_pkg::OUT_W-1:0]    block_probability_o
);
  import elp_pkg::*;

  elp_cmd_t cmd;
  elp_sts_t sts;

  elp_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  elp_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .channels_i          (channels_i),
    .offered_load_i      (offered_load_i),
    .idle_probability_o  (idle_probability_o),
    .block_probability_o (block_probability_o)
  );

endmodule

[hdl/elp_checker.sv]
// port-level checks for the erlang loss probability block, bound to the top level
module elp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [elp_pkg::CHAN_W-1:0]   channels_i,
  input logic [elp_pkg::ALPHA_W-1:0]  offered_load_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [elp_pkg::OUT_W-1:0]    idle_probability_o,
  input logic [elp_pkg::OUT_W-1:0]    block_probability_o
);
  import elp_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q, pending_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // items taken in whose result has not been transferred out yet
  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(idle_probability_o) &&
      $stable(block_probability_o))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled while an item is being worked on");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result shown without an item taken in");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two items outstanding");

endmodule

bind erlang_loss_probability elp_checker u_elp_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the erlang loss probability block
module testbench;

  import elp_pkg::*;

  localparam int MAX_CHANNELS     = 16;
  localparam int FRAC_BITS        = 16;
  localparam int PHASE_ITEMS      = 185;
  localparam int HOLD_CYCLES      = 2000;
  localparam int SETTLE_CYCLES    = 1000;
  localparam int WATCHDOG_LIMIT   = 12000;
  localparam logic [63:0] TERM_CAP = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] PROB_CAP = 64'h1_FFFF;

  // expected probabilities per accepted item, oldest first
  class loss_scoreboard;
    typedef struct packed {
      logic [OUT_W-1:0] idle_p;
      logic [OUT_W-1:0] block_p;
    } prob_pair_t;

    prob_pair_t    expected_probs[$];
    int unsigned   errors;
    logic [63:0]   last_term;
    logic [63:0]   last_sum;
    logic [4:0]    last_steps;

    function new();
      errors     = 0;
      last_term  = '0;
      last_sum   = '0;
      last_steps = '0;
    endfunction

    // running-term erlang b series with truncation and saturation
    function void note_input(input logic [CHAN_W-1:0] chans, input logic [ALPHA_W-1:0] load);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] prod;
      logic [63:0] p0;
      logic [63:0] blk;
      logic [4:0]  n;
      prob_pair_t  res;
      int          k;
      n    = (chans > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : chans;
      term = 64'd1 << FRAC_BITS;
      sum  = term;
      for (k = 1; k <= n; k++) begin
        prod = term * 64'(load);
        term = (prod / 64'(k)) >> FRAC_BITS;
        if (term > TERM_CAP) term = TERM_CAP;
        sum = sum + term;
        if (sum > TERM_CAP) sum = TERM_CAP;
      end
      p0  = (64'd1 << (2 * FRAC_BITS)) / sum;
      blk = (p0 * term) >> FRAC_BITS;
      last_term   = term;
      last_sum    = sum;
      last_steps  = n;
      res.idle_p  = OUT_W'((p0 > PROB_CAP) ? PROB_CAP : p0);
      res.block_p = OUT_W'((blk > PROB_CAP) ? PROB_CAP : blk);
      expected_probs = {expected_probs, res};
    endfunction

    function void check_result(input logic [OUT_W-1:0] idle_p, input logic [OUT_W-1:0] block_p);
      prob_pair_t exp_p;
      if (expected_probs.size() == 0) begin
        $error("unexpected result: idle_probability %0h block_probability %0h", idle_p, block_p);
        errors++;
        return;
      end
      exp_p = expected_probs.pop_front();
      if (idle_p !== exp_p.idle_p) begin
        $error("idle_probability: expected %0h, got %0h", exp_p.idle_p, idle_p);
        errors++;
      end
      if (block_p !== exp_p.block_p) begin
        $error("block_probability: expected %0h, got %0h", exp_p.block_p, block_p);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CHAN_W-1:0]  channels_i;
  logic [ALPHA_W-1:0] offered_load_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [OUT_W-1:0]   idle_probability_o;
  logic [OUT_W-1:0]   block_probability_o;

  loss_scoreboard sb = new();
  int unsigned    idle_pct;
  int unsigned    stall_pct;
  int unsigned    hold_requests;
  int unsigned    quiet_cycles;

  erlang_loss_probability #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .channels_i         (channels_i),
    .offered_load_i     (offered_load_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .idle_probability_o (idle_probability_o),
    .block_probability_o(block_probability_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(idle_probability_o, block_probability_o);
      if (in_valid_i && !in_stall_o) sb.note_input(channels_i, offered_load_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic [CHAN_W-1:0] chans, input logic [ALPHA_W-1:0] load);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    channels_i     <= chans;
    offered_load_i <= load;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic wait_drained();
    while (sb.expected_probs.size() != 0) @(posedge clk_i);
  endtask

  // mostly few channels to keep the run short, with some clamped counts
  function automatic logic [CHAN_W-1:0] pick_channels();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return CHAN_W'($urandom_range(4));
    if (r < 90) return CHAN_W'($urandom_range(16, 5));
    return CHAN_W'($urandom_range(31, 17));
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_load();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 20) return ALPHA_W'($urandom_range(20'hFFFFF));
    if (r < 85) return ALPHA_W'($urandom_range(20'h3FFFF));
    return ALPHA_W'($urandom_range(20'hAFFFF, 20'h40000));
  endfunction

  initial begin
    in_valid_i     <= 1'b0;
    channels_i     <= '0;
    offered_load_i <= '0;
    rst_ni         <= 1'b0;
    stall_pct      <= 0;
    hold_requests  <= 0;
    quiet_cycles   <= 0;
    idle_pct        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no channels, zero load, clamped counts, field extremes
    send_item(5'd0,  20'h00000);
    send_item(5'd0,  20'hFFFFF);
    send_item(5'd1,  20'h00000);
    send_item(5'd1,  20'h00001);
    send_item(5'd1,  20'h10000);
    send_item(5'd5,  20'h00000);
    send_item(5'd16, 20'h00000);
    send_item(5'd16, 20'hFFFFF);
    send_item(5'd16, 20'h10000);
    send_item(5'd17, 20'h20000);
    send_item(5'd31, 20'hFFFFF);
    send_item(5'd31, 20'h00001);
    send_item(5'd2,  20'h0FFFF);
    send_item(5'd3,  20'h55555);
    send_item(5'd4,  20'hAAAAA);
    send_item(5'd8,  20'h80000);
    send_item(5'd10, 20'h7FFFF);
    send_item(5'd15, 20'hC0000);
    send_item(5'd12, 20'h08000);
    send_item(5'd7,  20'h3FFFF);
    send_item(5'd16, 20'h00001);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  hold_requests <= hold_requests + 1; end
        1: begin idle_pct = 65; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 65; end
        default: begin idle_pct = 14; stall_pct <= 14; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(pick_channels(), pick_load());
      if (phase == 1) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_probs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
